/* hw/rtl/vector_quantizer_best_match_train_top_assert.svh */
// assertion macros for the vector quantizer top level
// no dependencies
`ifndef VECTOR_QUANTIZER_BEST_MATCH_TRAIN_TOP_ASSERT_SVH
`define VECTOR_QUANTIZER_BEST_MATCH_TRAIN_TOP_ASSERT_SVH
// implication checked every clock outside reset
`define VQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define VQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hw/rtl/vqbm_pkg.sv */
// package for the vector quantizer: constants, types, state enum
// no dependencies
package vqbm_pkg;
  localparam int MAX_NODES_DEF  = 64;
  localparam int MAX_DIMS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 16;
  localparam int NODE_W = 6;
  localparam int ELEM_W = 5;
  localparam int IN_W   = 16;
  localparam int DIST_W = 37;
  localparam int CNODE_W = 7;
  localparam int CDIM_W  = 6;
  localparam int RATE_W  = 16;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_TRAIN = 2'd1;
  localparam logic [1:0] CMD_MAP   = 2'd2;

  localparam logic [1:0] REG_NODES = 2'd0;
  localparam logic [1:0] REG_DIMS  = 2'd1;
  localparam logic [1:0] REG_RATE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SRCH, ST_UPD, ST_OUT
  } vqbm_state_t;

  typedef struct packed {
    logic load_wr;
    logic samp_wr;
    logic srch_start;
    logic upd_start;
    logic out_load;
  } vqbm_cmd_t;

  typedef struct packed {
    logic srch_done;
    logic upd_done;
  } vqbm_sts_t;
endpackage

/* hw/rtl/vqbm_ram.sv */
// generic single-port-write ram with registered read
// no dependencies
module vqbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/vqbm_ctrl.sv */
// controller state machine for the vector quantizer
// depends on vqbm_pkg
module vqbm_ctrl import vqbm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic        in_last_element,
  output logic        out_valid,
  input  logic        out_ready,
  output vqbm_cmd_t   cmd,
  input  vqbm_sts_t   sts,
  output logic        train_r
);
  vqbm_state_t state_r, state_nxt;
  logic train_nxt, out_valid_r, out_valid_nxt;
  logic acc;

  assign acc = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      train_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      train_r <= train_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    train_nxt = train_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (acc) begin
          cmd.load_wr = (in_command == CMD_LOAD);
          cmd.samp_wr = (in_command == CMD_TRAIN) || (in_command == CMD_MAP);
          if (cmd.samp_wr && in_last_element) begin
            cmd.srch_start = 1'b1;
            train_nxt = (in_command == CMD_TRAIN);
            state_nxt = ST_SRCH;
          end
        end
      end
      ST_SRCH: begin
        if (sts.srch_done) begin
          if (train_r) begin
            cmd.upd_start = 1'b1;
            state_nxt = ST_UPD;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_UPD: begin
        if (sts.upd_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

/* hw/rtl/vqbm_dp.sv */
// datapath: codebook, sample buffer, distance search and winner update
// depends on vqbm_pkg and vqbm_ram
module vqbm_dp import vqbm_pkg::*; #(
  parameter int MAX_NODES  = MAX_NODES_DEF,
  parameter int MAX_DIMS   = MAX_DIMS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vqbm_cmd_t          cmd,
  output vqbm_sts_t          sts,
  input  logic [NODE_W-1:0]  in_node_index,
  input  logic [ELEM_W-1:0]  in_element_index,
  input  logic signed [IN_W-1:0] in_element_value,
  input  logic [CNODE_W-1:0] nodes_in_use,
  input  logic [CDIM_W-1:0]  dims_in_use,
  input  logic [RATE_W-1:0]  learn_rate,
  input  logic               train,
  output logic [NODE_W-1:0]  out_best_node,
  output logic [DIST_W-1:0]  out_best_distance,
  output logic               out_was_training
);
  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CB_DEPTH = MAX_NODES * MAX_DIMS;
  localparam int AW = $clog2(CB_DEPTH) > 0 ? $clog2(CB_DEPTH) : 1;
  localparam int NC_W = $clog2(MAX_NODES + 1);
  localparam int DC_W = $clog2(MAX_DIMS + 1);
  localparam int VB = VALUE_BITS;
  localparam int SQ_W = 2 * (VB + 1);
  localparam int PR_W = VB + 1 + RATE_W + 1;
  localparam logic signed [VB+1:0] VMAX = (VB+2)'((64'sd1 <<< (VB - 1)) - 1);
  localparam logic signed [VB+1:0] VMIN = -VMAX - (VB+2)'(1);

  function automatic logic signed [VB-1:0] sat_in(input logic signed [IN_W-1:0] v);
    logic signed [VB+IN_W:0] x;
    x = (VB+IN_W+1)'(v);
    if (x > (VB+IN_W+1)'(VMAX)) return VMAX[VB-1:0];
    if (x < (VB+IN_W+1)'(VMIN)) return VMIN[VB-1:0];
    return x[VB-1:0];
  endfunction

  // effective counts
  logic [NC_W-1:0] n_eff;
  logic [DC_W-1:0] d_eff;
  always_comb begin
    if (nodes_in_use == '0) n_eff = NC_W'(1);
    else if (32'(nodes_in_use) > MAX_NODES) n_eff = NC_W'(MAX_NODES);
    else n_eff = NC_W'(nodes_in_use);
    if (dims_in_use == '0) d_eff = DC_W'(1);
    else if (32'(dims_in_use) > MAX_DIMS) d_eff = DC_W'(MAX_DIMS);
    else d_eff = DC_W'(dims_in_use);
  end

  // sample buffer, read at one counter address
  logic [VB-1:0] sb_rd;
  logic sb_we;
  logic [DW-1:0] sb_wa;

  // walk counters; pipeline: issue, ram read, align, difference, square, accumulate
  logic [NW-1:0] node_r, node_nxt;
  logic [DW-1:0] dim_r, dim_nxt;
  logic srch_r, upd_r, issue;
  logic v1_r, v2_r, last1_r, last2_r, v3_r, last3_r;
  logic [NW-1:0] n1_r, n2_r, n3_r;
  logic [DW-1:0] d1_r, d2_r, d3_r;
  logic signed [VB:0] diff3_r;
  logic [SQ_W-1:0] sq4_r;
  logic v4_r, last4_r;
  logic [NW-1:0] n4_r;
  logic [DIST_W-1:0] acc_r, best_d_r;
  logic [NW-1:0] best_n_r;
  logic have_r;
  logic upd1_r, upd2_r, upd_dp_r;
  logic [VB-1:0] cb_rd_q;

  logic cb_we;
  logic [AW-1:0] cb_wa, cb_ra;
  logic [VB-1:0] cb_wd, cb_rd;

  vqbm_ram #(.WIDTH(VB), .DEPTH(CB_DEPTH)) u_cb (
    .clk(clk), .we(cb_we), .waddr(cb_wa), .wdata(cb_wd), .raddr(cb_ra), .rdata(cb_rd)
  );

  vqbm_ram #(.WIDTH(VB), .DEPTH(MAX_DIMS)) u_sb (
    .clk(clk), .we(sb_we), .waddr(sb_wa), .wdata(sat_in(in_element_value)),
    .raddr(d1_r), .rdata(sb_rd)
  );

  assign issue = srch_r || upd_r;
  assign cb_ra = AW'(32'(node_r) * MAX_DIMS + 32'(dim_r));

  logic at_last_dim, at_last_node, walk_end;
  assign at_last_dim  = (DC_W'(dim_r) + DC_W'(1)) == d_eff;
  assign at_last_node = (NC_W'(node_r) + NC_W'(1)) == n_eff;
  assign walk_end = upd_r ? at_last_dim : (at_last_dim && at_last_node);

  always_comb begin
    node_nxt = node_r;
    dim_nxt = dim_r;
    if (cmd.srch_start) begin
      node_nxt = '0;
      dim_nxt = '0;
    end else if (cmd.upd_start) begin
      node_nxt = best_n_r;
      dim_nxt = '0;
    end else if (issue) begin
      if (at_last_dim) begin
        dim_nxt = '0;
        node_nxt = node_r + NW'(1);
      end else begin
        dim_nxt = dim_r + DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_r <= 1'b0;
      upd_r <= 1'b0;
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else begin
      if (cmd.srch_start) srch_r <= 1'b1;
      else if (srch_r && walk_end) srch_r <= 1'b0;
      if (cmd.upd_start) upd_r <= 1'b1;
      else if (upd_r && walk_end) upd_r <= 1'b0;
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r && !upd_r && !(v3_r && upd_dp_r);
    end
  end

  // update walk flag follows data down the pipe
  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    dim_r <= dim_nxt;
    upd1_r <= upd_r;
    upd2_r <= upd1_r;
    upd_dp_r <= upd2_r;
    last1_r <= walk_end;
    last2_r <= last1_r;
    last3_r <= last2_r;
    last4_r <= last3_r;
    n1_r <= node_r; n2_r <= n1_r; n3_r <= n2_r; n4_r <= n3_r;
    d1_r <= dim_r; d2_r <= d1_r; d3_r <= d2_r;
    diff3_r <= (VB+1)'($signed(sb_rd)) - (VB+1)'($signed(cb_rd_q));
    sq4_r <= SQ_W'($signed(diff3_r) * $signed(diff3_r));
  end

  // align ram data with buffer read
  always_ff @(posedge clk) cb_rd_q <= cb_rd;

  // sample and codebook data meet at stage 2
  // accumulate and compare
  logic [DIST_W-1:0] acc_sum;
  logic dim0_4_r;
  logic d0_3_r;
  always_ff @(posedge clk) begin
    d0_3_r <= (d2_r == '0);
    dim0_4_r <= d0_3_r;
  end
  assign acc_sum = (dim0_4_r ? '0 : acc_r) + DIST_W'(sq4_r);

  logic end4;
  logic [DC_W-1:0] d_eff_m1;
  logic [DW-1:0] d3_last_chk;
  always_ff @(posedge clk) d3_last_chk <= d3_r;
  assign d_eff_m1 = d_eff - DC_W'(1);
  assign end4 = (DC_W'(d3_last_chk) == d_eff_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      if (cmd.srch_start) have_r <= 1'b0;
      else if (v4_r && end4) have_r <= 1'b1;
    end
    if (v4_r) acc_r <= acc_sum;
    if (v4_r && end4 && (!have_r || acc_sum < best_d_r)) begin
      best_d_r <= acc_sum;
      best_n_r <= n4_r;
    end
  end

  // update: stage 3 holds sample and weight aligned
  logic signed [VB-1:0] w3_r;
  logic signed [PR_W-1:0] prod4_r;
  logic signed [VB-1:0] w4_r;
  logic [AW-1:0] wa4_r;
  logic u4_r;
  always_ff @(posedge clk) begin
    w3_r <= cb_rd_q;
    w4_r <= w3_r;
    prod4_r <= PR_W'(diff3_r) * $signed({1'b0, learn_rate});
    wa4_r <= AW'(32'(n3_r) * MAX_DIMS + 32'(d3_r));
    if (!rst_n) u4_r <= 1'b0;
    else u4_r <= v3_r && upd_dp_r;
  end
  logic signed [VB+1:0] upd_val;
  assign upd_val = (VB+2)'(w4_r) + (VB+2)'(prod4_r >>> RATE_W);

  logic upd_end_r;
  always_ff @(posedge clk) begin
    if (!rst_n) upd_end_r <= 1'b0;
    else upd_end_r <= u4_r && last4_r;
  end

  always_comb begin
    cb_we = 1'b0;
    cb_wa = AW'(32'(in_node_index) * MAX_DIMS + 32'(in_element_index));
    cb_wd = sat_in(in_element_value);
    if (u4_r) begin
      cb_we = 1'b1;
      cb_wa = wa4_r;
      if (upd_val > VMAX) cb_wd = VMAX[VB-1:0];
      else if (upd_val < VMIN) cb_wd = VMIN[VB-1:0];
      else cb_wd = upd_val[VB-1:0];
    end else if (cmd.load_wr && 32'(in_node_index) < MAX_NODES
                 && 32'(in_element_index) < MAX_DIMS) begin
      cb_we = 1'b1;
    end
  end

  assign sb_we = cmd.samp_wr && (32'(in_element_index) < MAX_DIMS);
  assign sb_wa = DW'(in_element_index);

  logic srch_end_r;
  always_ff @(posedge clk) begin
    if (!rst_n) srch_end_r <= 1'b0;
    else srch_end_r <= v4_r && last4_r;
  end
  assign sts.srch_done = srch_end_r;
  assign sts.upd_done = upd_end_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_best_node <= NODE_W'(best_n_r);
      out_best_distance <= best_d_r;
      out_was_training <= train;
    end
  end
endmodule

/* hw/rtl/vector_quantizer_best_match_train_top.sv */
// a training sample adds an update walk over the winning node's elements after its search
// throughput: one codebook element per cycle; input held off from a last item until its result loads
// load and non-last sample items are accepted whenever the controller is idle; an untaken result delays the next one
// synchronous active-low reset clears control and presets config; data and memories keep contents
// depends on vqbm_pkg, vqbm_ctrl, vqbm_dp, vqbm_ram and the assertion header
`include "vector_quantizer_best_match_train_top_assert.svh"
module vector_quantizer_best_match_train_top import vqbm_pkg::*; #(
  parameter int MAX_NODES  = MAX_NODES_DEF,
  parameter int MAX_DIMS   = MAX_DIMS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [NODE_W-1:0]  in_node_index,
  input  logic [ELEM_W-1:0]  in_element_index,
  input  logic signed [IN_W-1:0] in_element_value,
  input  logic               in_last_element,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [NODE_W-1:0]  out_best_node,
  output logic [DIST_W-1:0]  out_best_distance,
  output logic               out_was_training,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [RATE_W-1:0]  cfg_data
);
  vqbm_cmd_t cmd;
  vqbm_sts_t sts;
  logic train;
  logic [CNODE_W-1:0] nodes_r;
  logic [CDIM_W-1:0] dims_r;
  logic [RATE_W-1:0] rate_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r <= CNODE_W'(64);
      dims_r <= CDIM_W'(32);
      rate_r <= RATE_W'(13107);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NODES: nodes_r <= cfg_data[CNODE_W-1:0];
        REG_DIMS:  dims_r <= cfg_data[CDIM_W-1:0];
        REG_RATE:  rate_r <= cfg_data;
        default: ;
      endcase
    end
  end

  vqbm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_last_element(in_last_element),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts), .train_r(train)
  );

  vqbm_dp #(.MAX_NODES(MAX_NODES), .MAX_DIMS(MAX_DIMS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_node_index(in_node_index), .in_element_index(in_element_index),
    .in_element_value(in_element_value), .nodes_in_use(nodes_r), .dims_in_use(dims_r),
    .learn_rate(rate_r), .train(train), .out_best_node(out_best_node),
    .out_best_distance(out_best_distance), .out_was_training(out_was_training)
  );

  `VQ_ASSERT_IMP(a_one_cmd, 1'b1, !(cmd.srch_start && cmd.upd_start))
  `VQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `VQ_ASSERT_IMP(a_no_done_pair, 1'b1, !(sts.srch_done && sts.upd_done))
endmodule
